// ----- rtl/core/ccsb_pkg.sv -----
// ccsb_pkg: types, widths and constants shared by the sprite blitter files
// no dependencies; compiled before the interfaces and modules
`timescale 1ns / 1ps
`default_nettype none

package ccsb_pkg;

    // largest sprite side in pixels
    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = CNT_W + 1;

    // fixed field widths
    localparam int POS_W    = 16;
    localparam int ORG_W    = POS_W + 1;
    localparam int CTR_W    = 12;
    localparam int PCT_W    = 7;
    localparam int PIX_W    = 32;
    localparam int KEY_W    = 24;
    localparam int ADDR_W   = 26;
    localparam int DST_W    = 13;
    localparam int PITCH_W  = 15;
    localparam int PROD_W   = DIM_W + PCT_W;

    localparam int PCT_FULL = 100;

    // apb side
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [KEY_W-1:0]   RST_COLOR_KEY   = KEY_W'(0);
    localparam logic [DST_W-1:0]   RST_DEST_WIDTH  = DST_W'(640);
    localparam logic [DST_W-1:0]   RST_DEST_HEIGHT = DST_W'(480);
    localparam logic [PITCH_W-1:0] RST_DEST_PITCH  = PITCH_W'(2560);

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_COLOR_KEY   = 2'd0,
        REG_DEST_WIDTH  = 2'd1,
        REG_DEST_HEIGHT = 2'd2,
        REG_DEST_PITCH  = 2'd3
    } t_reg_idx;

    // register file contents seen by the datapath
    typedef struct packed {
        logic [KEY_W-1:0]   color_key;
        logic [DST_W-1:0]   dest_width;
        logic [DST_W-1:0]   dest_height;
        logic [PITCH_W-1:0] dest_pitch;
    } t_cfg;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [POS_W-1:0]   draw_x;
        logic signed [POS_W-1:0]   draw_y;
        logic [DIM_W-1:0]          sprite_width;
        logic [DIM_W-1:0]          sprite_height;
        logic [CTR_W-1:0]          center_x;
        logic [CTR_W-1:0]          center_y;
        logic [PCT_W-1:0]          draw_percent;
        logic                      keyed_mode;
        logic [PIX_W-1:0]          pixel_value;
    } t_item;

    typedef struct packed {
        logic                write_enable;
        logic [ADDR_W-1:0]   dest_address;
        logic [PIX_W-1:0]    write_data;
        logic                last_pixel;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/ccsb_item_if.sv -----
// ccsb_item_if: valid/ready channel carrying start and pixel items into the blitter
// depends on ccsb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ccsb_item_if;
    import ccsb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [POS_W-1:0] draw_x;
    logic signed [POS_W-1:0] draw_y;
    logic [DIM_W-1:0]        sprite_width;
    logic [DIM_W-1:0]        sprite_height;
    logic [CTR_W-1:0]        center_x;
    logic [CTR_W-1:0]        center_y;
    logic [PCT_W-1:0]        draw_percent;
    logic                    keyed_mode;
    logic [PIX_W-1:0]        pixel_value;

    modport source (
        output valid, opcode, draw_x, draw_y, sprite_width, sprite_height,
               center_x, center_y, draw_percent, keyed_mode, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, draw_x, draw_y, sprite_width, sprite_height,
               center_x, center_y, draw_percent, keyed_mode, pixel_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/ccsb_result_if.sv -----
// ccsb_result_if: valid/ready channel carrying one destination transfer per sprite pixel
// depends on ccsb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ccsb_result_if;
    import ccsb_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  write_data;
    logic              last_pixel;

    modport source (
        output valid, write_enable, dest_address, write_data, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, write_enable, dest_address, write_data, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/clipped_colorkey_sprite_blitter.sv -----
// clipped_colorkey_sprite_blitter: color-keyed 32-bit sprite blit with destination clipping
// depends on ccsb_pkg, ccsb_item_if, ccsb_result_if and ccsb_apb_regs
//
// usage:
//   i_item takes a start item (opcode 0) with draw position, sprite size, center point,
//   width percentage and keyed mode, then the sprite pixels (opcode 1) in raster order.
//   every pixel of an active draw gives one transfer on o_result: write enable, byte
//   address row * pitch + column * 4, the pixel itself and a last-pixel flag. start
//   items and pixels that arrive with no draw active give no transfer.
//   the apb port holds color key, destination width, height and pitch; write it only
//   while no draw is in flight.
// timing:
//   an accepted item is held in the input register and, once the output register is free,
//   a pixel's result is loaded into the output register, where it is valid on o_result.
//   one item per cycle is sustained while o_result is not stalled; the per-pixel clip, key
//   compare and one 13x15 address multiply all sit between the input and output registers.
// reset and stall:
//   synchronous active-low reset empties both registers, ends any draw and restores the
//   register defaults. while o_result is stalled the result register holds and i_item
//   still takes one more item into the input register; items that give no result keep
//   flowing even behind a stalled result.
`timescale 1ns / 1ps
`default_nettype none

module clipped_colorkey_sprite_blitter
    import ccsb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ccsb_item_if.sink              i_item,
    ccsb_result_if.source          o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;

    ccsb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic  r_in_valid;
    t_item r_in;

    // draw state
    logic [ORG_W-1:0]  r_org_x, n_org_x;
    logic [ORG_W-1:0]  r_org_y, n_org_y;
    logic [DIM_W-1:0]  r_width, n_width;
    logic [DIM_W-1:0]  r_height, n_height;
    logic [PROD_W-1:0] r_len_prod, n_len_prod;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic              r_keyed, n_keyed;
    logic              r_busy, n_busy;

    // result register
    logic    r_res_valid;
    t_result r_res, n_res;

    logic in_take, in_consume, is_start, is_pixel, res_load, out_free;

    assign is_start   = r_in_valid && (r_in.opcode == OP_START);
    assign is_pixel   = r_in_valid && (r_in.opcode == OP_PIXEL) && r_busy;
    assign out_free   = !r_res_valid || o_result.ready;
    assign res_load   = is_pixel && out_free;
    // a pixel waits only when it needs the result register and that is full and not being taken
    assign in_consume = r_in_valid && (!is_pixel || out_free);
    assign i_item.ready = !r_in_valid || in_consume;
    assign in_take    = i_item.valid && i_item.ready;

    // start item setup
    logic [DIM_W-1:0] w_sat, h_sat;
    logic [PCT_W-1:0] pct_sat;

    always_comb begin
        w_sat   = (r_in.sprite_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_in.sprite_width;
        h_sat   = (r_in.sprite_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                          : r_in.sprite_height;
        pct_sat = (r_in.draw_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                         : r_in.draw_percent;
    end

    // pixel datapath
    logic signed [ORG_W:0]         pos_x, pos_y;
    logic                          in_dest, in_len, not_key, we, last;
    logic [DIM_W-1:0]              col_p1, row_p1;
    logic [PROD_W-1:0]             col_scaled;
    logic [DST_W+PITCH_W-1:0]      row_off;
    logic [ADDR_W-1:0]             addr;

    always_comb begin
        pos_x  = $signed({r_org_x[ORG_W-1], r_org_x})
               + $signed({{(ORG_W+1-CNT_W){1'b0}}, r_col});
        pos_y  = $signed({r_org_y[ORG_W-1], r_org_y})
               + $signed({{(ORG_W+1-CNT_W){1'b0}}, r_row});
        in_dest = !pos_x[ORG_W] && !pos_y[ORG_W]
               && (pos_x[ORG_W-1:0] < ORG_W'(cfg.dest_width))
               && (pos_y[ORG_W-1:0] < ORG_W'(cfg.dest_height));
        col_p1 = {1'b0, r_col} + DIM_W'(1);
        row_p1 = {1'b0, r_row} + DIM_W'(1);
        // column < floor(width * pct / 100)  <=>  100 * (column + 1) <= width * pct
        col_scaled = PROD_W'(col_p1) * PROD_W'(PCT_FULL);
        in_len  = col_scaled <= r_len_prod;
        not_key = !r_keyed || (r_in.pixel_value[KEY_W-1:0] != cfg.color_key);
        we      = in_dest && in_len && not_key;
        last    = (col_p1 >= r_width) && (row_p1 >= r_height);
        // inside the destination both coordinates fit the register width
        row_off = {{PITCH_W{1'b0}}, pos_y[DST_W-1:0]}
                * {{DST_W{1'b0}}, cfg.dest_pitch};
        addr    = row_off[ADDR_W-1:0] + ADDR_W'({pos_x[DST_W-1:0], 2'b00});

        n_res.write_enable = we;
        n_res.dest_address = we ? addr : '0;
        n_res.write_data   = r_in.pixel_value;
        n_res.last_pixel   = last;
    end

    always_comb begin
        n_org_x    = r_org_x;
        n_org_y    = r_org_y;
        n_width    = r_width;
        n_height   = r_height;
        n_len_prod = r_len_prod;
        n_col      = r_col;
        n_row      = r_row;
        n_keyed    = r_keyed;
        n_busy     = r_busy;
        if (in_consume && is_start) begin
            n_org_x    = ORG_W'(r_in.draw_x) - ORG_W'(r_in.center_x);
            n_org_y    = ORG_W'(r_in.draw_y) - ORG_W'(r_in.center_y);
            n_width    = w_sat;
            n_height   = h_sat;
            n_len_prod = PROD_W'(w_sat) * PROD_W'(pct_sat);
            n_keyed    = r_in.keyed_mode;
            n_col      = '0;
            n_row      = '0;
            n_busy     = (w_sat != '0) && (h_sat != '0);
        end else if (res_load) begin
            if (last) begin
                n_busy = 1'b0;
                n_col  = '0;
                n_row  = '0;
            end else if (col_p1 >= r_width) begin
                n_col = '0;
                n_row = row_p1[CNT_W-1:0];
            end else begin
                n_col = col_p1[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_len_prod  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_keyed     <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (in_consume) begin
                r_in_valid <= 1'b0;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
            r_org_x    <= n_org_x;
            r_org_y    <= n_org_y;
            r_width    <= n_width;
            r_height   <= n_height;
            r_len_prod <= n_len_prod;
            r_col      <= n_col;
            r_row      <= n_row;
            r_keyed    <= n_keyed;
            r_busy     <= n_busy;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode        <= t_opcode'(i_item.opcode);
            r_in.draw_x        <= i_item.draw_x;
            r_in.draw_y        <= i_item.draw_y;
            r_in.sprite_width  <= i_item.sprite_width;
            r_in.sprite_height <= i_item.sprite_height;
            r_in.center_x      <= i_item.center_x;
            r_in.center_y      <= i_item.center_y;
            r_in.draw_percent  <= i_item.draw_percent;
            r_in.keyed_mode    <= i_item.keyed_mode;
            r_in.pixel_value   <= i_item.pixel_value;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid        = r_res_valid;
    assign o_result.write_enable = r_res.write_enable;
    assign o_result.dest_address = r_res.dest_address;
    assign o_result.write_data   = r_res.write_data;
    assign o_result.last_pixel   = r_res.last_pixel;

    // a draw ends only on its last pixel or when a new start item replaces it
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(res_load && last) || $past(in_consume && is_start))
        else $error("draw ended without last pixel or start item");

    // counters stay inside the sprite while drawing
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_col} < r_width) && ({1'b0, r_row} < r_height))
        else $error("sprite counters outside sprite size");

    // skipped pixels carry a zero address
    a_skip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !r_res.write_enable |-> r_res.dest_address == '0)
        else $error("skipped pixel with nonzero address");

    // an empty result register never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_valid |-> i_item.ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ----- rtl/core/ccsb_apb_regs.sv -----
// ccsb_apb_regs: apb register file for color key and destination geometry
// depends on ccsb_pkg (t_cfg, t_reg_idx, reset values)
`timescale 1ns / 1ps
`default_nettype none

module ccsb_apb_regs
    import ccsb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_key   <= RST_COLOR_KEY;
            r_cfg.dest_width  <= RST_DEST_WIDTH;
            r_cfg.dest_height <= RST_DEST_HEIGHT;
            r_cfg.dest_pitch  <= RST_DEST_PITCH;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COLOR_KEY:   r_cfg.color_key   <= pwdata[KEY_W-1:0];
                REG_DEST_WIDTH:  r_cfg.dest_width  <= pwdata[DST_W-1:0];
                REG_DEST_HEIGHT: r_cfg.dest_height <= pwdata[DST_W-1:0];
                REG_DEST_PITCH:  r_cfg.dest_pitch  <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLOR_KEY:   prdata = APB_DW'(r_cfg.color_key);
            REG_DEST_WIDTH:  prdata = APB_DW'(r_cfg.dest_width);
            REG_DEST_HEIGHT: prdata = APB_DW'(r_cfg.dest_height);
            REG_DEST_PITCH:  prdata = APB_DW'(r_cfg.dest_pitch);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
